// ----- rtl/core/slp_pkg.sv -----
// ----------------------------------------------------------------------------
// slp_pkg
// Shared types, character codes and helpers for the serial-line CAN frame
// parser.
// ----------------------------------------------------------------------------
package slp_pkg;

    localparam int MAX_DATA_BYTES_DEF = 8;
    localparam int QUEUE_DEPTH        = 2;
    localparam int CNT_W              = 5;

    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_STD_DATA = 8'h74;
    localparam logic [7:0] CH_STD_RTR  = 8'h72;
    localparam logic [7:0] CH_EXT_DATA = 8'h54;
    localparam logic [7:0] CH_EXT_RTR  = 8'h52;

    localparam int KIND_EXT = 0;
    localparam int KIND_RTR = 1;

    typedef struct packed {
        logic       is_cr;
        logic       is_type;
        logic [1:0] kind;
        logic       is_hex;
        logic [3:0] hex;
    } t_token;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_ID   = 6'b000010,
        PH_DLC  = 6'b000100,
        PH_DATA = 6'b001000,
        PH_DONE = 6'b010000,
        PH_SKIP = 6'b100000
    } t_phase;

    function automatic t_token classify(input logic [7:0] c);
        t_token t;
        t = '0;
        t.is_cr = (c == CH_CR);
        if (c == CH_STD_DATA) begin
            t.is_type = 1'b1;
        end else if (c == CH_STD_RTR) begin
            t.is_type = 1'b1;
            t.kind[KIND_RTR] = 1'b1;
        end else if (c == CH_EXT_DATA) begin
            t.is_type = 1'b1;
            t.kind[KIND_EXT] = 1'b1;
        end else if (c == CH_EXT_RTR) begin
            t.is_type = 1'b1;
            t.kind = 2'b11;
        end
        if (c >= 8'h30 && c <= 8'h39) begin
            t.is_hex = 1'b1;
            t.hex    = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            t.is_hex = 1'b1;
            t.hex    = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            t.is_hex = 1'b1;
            t.hex    = 4'(c - 8'h57);
        end
        return t;
    endfunction

endpackage

// ----- rtl/core/slp_if.sv -----
// ----------------------------------------------------------------------------
// slp_if
// Valid/ready channels: received characters in, parsed frames out.
// ----------------------------------------------------------------------------
interface slp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slp_frame_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame_id;
    logic        is_extended;
    logic        is_remote;
    logic [3:0]  data_length;
    logic [63:0] data_bytes;

    modport source (output valid, output frame_id, output is_extended, output is_remote,
                    output data_length, output data_bytes, input ready);
    modport sink   (input valid, input frame_id, input is_extended, input is_remote,
                    input data_length, input data_bytes, output ready);
endinterface

// ----- rtl/core/slp_front.sv -----
// ----------------------------------------------------------------------------
// slp_front
// Accepts characters and registers them as classified tokens.
// ----------------------------------------------------------------------------
module slp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    slp_byte_if.sink        i_rx,
    output logic            o_tok_valid,
    output slp_pkg::t_token o_tok,
    input  logic            i_tok_ready
);
    import slp_pkg::*;

    logic   r_valid;
    t_token r_tok;

    assign i_rx.ready  = !r_valid || i_tok_ready;
    assign o_tok_valid = r_valid;
    assign o_tok       = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_tok <= classify(i_rx.rx_byte);
        end
    end

endmodule

// ----- rtl/core/slp_queue.sv -----
// ----------------------------------------------------------------------------
// slp_queue
// Short token queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module slp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  slp_pkg::t_token i_push_tok,
    output logic            o_push_ready,
    output logic            o_pop_valid,
    output slp_pkg::t_token o_pop_tok,
    input  logic            i_pop_ready
);
    import slp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    t_token             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [LVL_W-1:0]   r_level;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_level != LVL_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_level != '0);
    assign o_pop_tok    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_level <= r_level + 1'b1;
            end else if (pop && !push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/slp_back.sv -----
// ----------------------------------------------------------------------------
// slp_back
// Line parser state machine and frame output register.
// ----------------------------------------------------------------------------
module slp_back #(
    parameter int MAX_DATA_BYTES = slp_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tok_valid,
    input  slp_pkg::t_token i_tok,
    output logic            o_tok_ready,
    slp_frame_if.source     o_frame
);
    import slp_pkg::*;

    localparam int DATA_W = 8 * MAX_DATA_BYTES;
    localparam int NIBS   = 2 * MAX_DATA_BYTES;
    localparam int NIB_W  = $clog2(NIBS);

    t_phase             r_phase, n_phase;
    logic [1:0]         r_kind, n_kind;
    logic [31:0]        r_id, n_id;
    logic [3:0]         r_len, n_len;
    logic [DATA_W-1:0]  r_data, n_data;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   cnt_inc;
    logic [NIB_W-1:0]   nib;
    logic               take;
    logic               emit;

    logic               r_out_valid;
    logic [31:0]        r_out_id;
    logic [1:0]         r_out_kind;
    logic [3:0]         r_out_len;
    logic [DATA_W-1:0]  r_out_data;

    assign o_tok_ready = !r_out_valid || o_frame.ready;
    assign take        = i_tok_valid && o_tok_ready;
    assign cnt_inc     = r_cnt + 1'b1;
    assign nib         = r_cnt[NIB_W-1:0] ^ NIB_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_id    = r_id;
        n_len   = r_len;
        n_data  = r_data;
        n_cnt   = r_cnt;
        emit    = 1'b0;
        if (i_tok.is_cr) begin
            emit    = (r_phase == PH_DONE);
            n_phase = PH_IDLE;
            n_kind  = '0;
            n_id    = '0;
            n_len   = '0;
            n_data  = '0;
            n_cnt   = '0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    n_kind = '0;
                    n_id   = '0;
                    n_len  = '0;
                    n_data = '0;
                    n_cnt  = '0;
                    if (i_tok.is_type) begin
                        n_kind  = i_tok.kind;
                        n_phase = PH_ID;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_ID: begin
                    if (!i_tok.is_hex) begin
                        n_phase = PH_SKIP;
                    end else begin
                        n_id  = {r_id[27:0], i_tok.hex};
                        n_cnt = cnt_inc;
                        if (cnt_inc >= (r_kind[KIND_EXT] ? CNT_W'(8) : CNT_W'(3))) begin
                            n_cnt   = '0;
                            n_phase = PH_DLC;
                        end
                    end
                end
                PH_DLC: begin
                    if (!i_tok.is_hex || i_tok.hex > 4'(MAX_DATA_BYTES)) begin
                        n_phase = PH_SKIP;
                    end else begin
                        n_len   = i_tok.hex;
                        n_cnt   = '0;
                        n_phase = (r_kind[KIND_RTR] || i_tok.hex == '0) ? PH_DONE : PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (!i_tok.is_hex) begin
                        n_phase = PH_SKIP;
                    end else begin
                        for (int k = 0; k < NIBS; k++) begin
                            if (nib == NIB_W'(k)) begin
                                n_data[4*k +: 4] = r_data[4*k +: 4] | i_tok.hex;
                            end
                        end
                        n_cnt = cnt_inc;
                        if (cnt_inc >= {r_len, 1'b0}) begin
                            n_phase = PH_DONE;
                        end
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                PH_SKIP: begin
                    n_phase = PH_SKIP;
                end
                default: begin
                    n_phase = PH_SKIP;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_kind  <= '0;
            r_id    <= '0;
            r_len   <= '0;
            r_data  <= '0;
            r_cnt   <= '0;
        end else if (take) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_id    <= n_id;
            r_len   <= n_len;
            r_data  <= n_data;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_out_id   <= r_id;
            r_out_kind <= r_kind;
            r_out_len  <= r_len;
            r_out_data <= r_data;
        end
    end

    assign o_frame.valid       = r_out_valid;
    assign o_frame.frame_id    = r_out_id;
    assign o_frame.is_extended = r_out_kind[KIND_EXT];
    assign o_frame.is_remote   = r_out_kind[KIND_RTR];
    assign o_frame.data_length = r_out_len;
    assign o_frame.data_bytes  = 64'(r_out_data);

endmodule

// ----- rtl/core/slcan_line_frame_parser_unit.sv -----
// A frame is valid once its carriage return passes classifier, queue and output register.
// Throughput: one character per cycle, limited by the single-token parser update.
// A full output register stalls the parser; the queue keeps input flowing a while.
// Reset: synchronous active-low i_rst_n clears the parser to idle and empties all stages.
// ----------------------------------------------------------------------------
// slcan_line_frame_parser_unit
// Serial-line ASCII CAN frame parser: classifier, token queue, line parser.
// ----------------------------------------------------------------------------
module slcan_line_frame_parser_unit #(
    parameter int MAX_DATA_BYTES = slp_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slp_byte_if.sink    i_rx,
    slp_frame_if.source o_frame
);
    import slp_pkg::*;

    logic   fr_valid;
    t_token fr_tok;
    logic   fr_ready;
    logic   q_valid;
    t_token q_tok;
    logic   q_ready;

    slp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (i_rx),
        .o_tok_valid (fr_valid),
        .o_tok       (fr_tok),
        .i_tok_ready (fr_ready)
    );

    slp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fr_valid),
        .i_push_tok   (fr_tok),
        .o_push_ready (fr_ready),
        .o_pop_valid  (q_valid),
        .o_pop_tok    (q_tok),
        .i_pop_ready  (q_ready)
    );

    slp_back #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .i_tok       (q_tok),
        .o_tok_ready (q_ready),
        .o_frame     (o_frame)
    );

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame.valid |-> o_frame.data_length <= 4'(MAX_DATA_BYTES))
        else $error("frame length above limit");

    a_remote_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frame.valid && o_frame.is_remote) |-> o_frame.data_bytes == '0)
        else $error("remote frame carries data");

    a_std_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frame.valid && !o_frame.is_extended) |-> o_frame.frame_id[31:12] == '0)
        else $error("standard id wider than 12 bits");

    a_empty_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frame.valid && o_frame.data_length == '0) |-> o_frame.data_bytes == '0)
        else $error("zero-length frame carries data");

endmodule
